// File: src/rsc_pkg.sv
`timescale 1ns / 1ps

package rsc_pkg;

    // Fixed field widths of the command and result transactions
    localparam int CMD_W    = 3;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 3;
    localparam int DEPTH_W  = 7;

    // Command codes; code seven is unused and acts as a no-op
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH = 3'd0,
        CMD_ADD  = 3'd1,
        CMD_SUB  = 3'd2,
        CMD_MUL  = 3'd3,
        CMD_DIV  = 3'd4,
        CMD_POP  = 3'd5,
        CMD_DUP  = 3'd6
    } cmd_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_FEW     = 3'd1,
        ST_DIVZERO = 3'd2,
        ST_EMPTY   = 3'd3,
        ST_FULL    = 3'd4
    } status_t;

    // Sequencer states of the top level
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_DIV,
        S_FIN
    } state_t;

endpackage

// File: src/rsc_div.sv
`timescale 1ns / 1ps

module rsc_div
    import rsc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DATA_W-1:0] dividend,
    input  logic [DATA_W-1:0] divisor,
    output logic              done,
    output logic [DATA_W-1:0] quotient
);

    localparam int STEP_W = $clog2(DATA_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DATA_W - 1);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] quo_reg;
    logic [DATA_W-1:0] dmag_reg;
    logic              neg_reg;

    logic [DATA_W-1:0] shifted;
    logic [DATA_W:0]   diff;

    // Shift in the next dividend bit and try one subtraction
    always_comb
    begin
        shifted = {rem_reg[DATA_W-2:0], quo_reg[DATA_W-1]};
        diff    = {1'b0, shifted} - {1'b0, dmag_reg};
    end

    // Control: one quotient bit per cycle after start
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: load magnitudes, then restoring steps
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg  <= dividend[DATA_W-1] ? (DATA_W'(0) - dividend) : dividend;
            dmag_reg <= divisor[DATA_W-1] ? (DATA_W'(0) - divisor) : divisor;
            rem_reg  <= '0;
            neg_reg  <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
        end
        else if (busy_reg)
        begin
            rem_reg <= diff[DATA_W] ? shifted : diff[DATA_W-1:0];
            quo_reg <= {quo_reg[DATA_W-2:0], ~diff[DATA_W]};
        end
    end

    // Apply the sign so the quotient truncates toward zero
    assign quotient = neg_reg ? (DATA_W'(0) - quo_reg) : quo_reg;
    assign done     = done_reg;

endmodule

// File: src/rpn_stack_calculator_top.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake           Payload
// command   in         in_valid/in_stall   cmd, operand
// result    out        out_valid/out_stall status, out_value, depth
//
// One command at a time; the next is taken once the current one has retired.
// Push, dup, no-op and refused commands retire from execute; pop from execute
// or read; add, sub and mul pass read and finish; divide also waits on the
// one-bit-a-cycle divider. Reset empties the stack and drops any pending result.
// A stalled result holds in the output register; the block keeps working
// on the next command and waits at its retire step until the register frees.

module rpn_stack_calculator_top
    import rsc_pkg::*;
#(
    parameter int STACK_DEPTH = 64
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [CMD_W-1:0]    cmd,
    input  logic signed [DATA_W-1:0] operand,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [STATUS_W-1:0] status,
    output logic signed [DATA_W-1:0] out_value,
    output logic [DEPTH_W-1:0]  depth
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam logic [CW-1:0] COUNT_FULL = CW'(STACK_DEPTH);

    // Entries below the top live in memory; the top lives in top_reg
    logic [DATA_W-1:0] stack_mem [STACK_DEPTH];

    state_t            state_reg, state_next;
    cmd_t              cmd_reg;
    logic [DATA_W-1:0] operand_reg;
    logic [CW-1:0]     count_reg, count_next;
    logic [DATA_W-1:0] top_reg, top_next;
    logic [DATA_W-1:0] res_reg, res_next;
    logic [DATA_W-1:0] rd_data_reg;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [DATA_W-1:0]   value_reg;
    logic [DEPTH_W-1:0]  depth_reg;

    logic              out_free;
    logic              cnt_zero, cnt_one, cnt_lt2, cnt_full, top_zero;
    logic              exec_read;
    logic [AW-1:0]     idx_top, idx_below;

    logic              retire;
    status_t           ret_status;
    logic [DATA_W-1:0] ret_value;
    logic              mem_we, mem_re;
    logic              div_start;
    logic              div_done;
    logic [DATA_W-1:0] div_quotient;

    // Decode stack occupancy and the read need of the current command
    always_comb
    begin
        out_free  = !out_valid_reg || !out_stall;
        cnt_zero  = (count_reg == '0);
        cnt_one   = (count_reg == CW'(1));
        cnt_lt2   = cnt_zero || cnt_one;
        cnt_full  = (count_reg == COUNT_FULL);
        top_zero  = (top_reg == '0);
        idx_top   = AW'(count_reg - CW'(1));
        idx_below = AW'(count_reg - CW'(2));
        exec_read = 1'b0;
        unique case (cmd_reg)
            CMD_ADD, CMD_SUB, CMD_MUL:
                exec_read = !cnt_lt2;
            CMD_DIV:
                exec_read = !cnt_lt2 && !top_zero;
            CMD_POP:
                exec_read = !cnt_lt2;
            default:
                exec_read = 1'b0;
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                    state_next = S_EXEC;
            S_EXEC:
                if (exec_read)
                    state_next = S_READ;
                else if (out_free)
                    state_next = S_IDLE;
            S_READ:
                unique case (cmd_reg)
                    CMD_POP:
                        if (out_free)
                            state_next = S_IDLE;
                    CMD_DIV:
                        state_next = S_DIV;
                    CMD_ADD, CMD_SUB, CMD_MUL:
                        state_next = S_FIN;
                    default:
                        state_next = S_IDLE;
                endcase
            S_DIV:
                if (div_done)
                    state_next = S_FIN;
            S_FIN:
                if (out_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // Outputs of the sequencer: retire, stack update, memory access
    always_comb
    begin
        retire     = 1'b0;
        ret_status = ST_OK;
        ret_value  = '0;
        count_next = count_reg;
        top_next   = top_reg;
        res_next   = res_reg;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        div_start  = 1'b0;
        unique case (state_reg)
            S_EXEC:
                unique case (cmd_reg)
                    CMD_PUSH:
                        if (cnt_full)
                        begin
                            ret_status = ST_FULL;
                            retire     = out_free;
                        end
                        else
                        begin
                            retire = out_free;
                            if (out_free)
                            begin
                                mem_we     = !cnt_zero;
                                top_next   = operand_reg;
                                count_next = count_reg + CW'(1);
                            end
                        end
                    CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV:
                        if (cnt_lt2)
                        begin
                            ret_status = ST_FEW;
                            retire     = out_free;
                        end
                        else if (cmd_reg == CMD_DIV && top_zero)
                        begin
                            ret_status = ST_DIVZERO;
                            retire     = out_free;
                        end
                        else
                        begin
                            mem_re = 1'b1;
                        end
                    CMD_POP:
                        if (cnt_zero)
                        begin
                            ret_status = ST_EMPTY;
                            retire     = out_free;
                        end
                        else if (cnt_one)
                        begin
                            retire = out_free;
                            if (out_free)
                            begin
                                ret_value  = top_reg;
                                count_next = count_reg - CW'(1);
                            end
                        end
                        else
                        begin
                            mem_re = 1'b1;
                        end
                    CMD_DUP:
                        if (cnt_zero)
                        begin
                            ret_status = ST_EMPTY;
                            retire     = out_free;
                        end
                        else if (cnt_full)
                        begin
                            ret_status = ST_FULL;
                            retire     = out_free;
                        end
                        else
                        begin
                            retire = out_free;
                            if (out_free)
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                    default:
                        retire = out_free;
                endcase
            S_READ:
                unique case (cmd_reg)
                    CMD_POP:
                        if (out_free)
                        begin
                            retire     = 1'b1;
                            ret_value  = top_reg;
                            top_next   = rd_data_reg;
                            count_next = count_reg - CW'(1);
                        end
                    CMD_ADD:
                        res_next = rd_data_reg + top_reg;
                    CMD_SUB:
                        res_next = rd_data_reg - top_reg;
                    CMD_MUL:
                        res_next = rd_data_reg * top_reg;
                    CMD_DIV:
                        div_start = 1'b1;
                    default:
                        res_next = res_reg;
                endcase
            S_DIV:
                if (div_done)
                    res_next = div_quotient;
            S_FIN:
                if (out_free)
                begin
                    retire     = 1'b1;
                    top_next   = res_reg;
                    count_next = count_reg - CW'(1);
                end
            default:
                retire = 1'b0;
        endcase
    end

    // Divide a by b over one bit a cycle
    rsc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (rd_data_reg),
        .divisor  (top_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Stack memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            stack_mem[idx_top] <= top_reg;
        if (mem_re)
            rd_data_reg <= stack_mem[idx_below];
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (retire)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers: capture the command, hold top and result
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            cmd_reg     <= cmd_t'(cmd);
            operand_reg <= operand;
        end
        top_reg <= top_next;
        res_reg <= res_next;
        if (retire)
        begin
            status_reg <= ret_status;
            value_reg  <= ret_value;
            depth_reg  <= DEPTH_W'(count_next);
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign out_value = value_reg;
    assign depth     = depth_reg;

endmodule
